/* design/idec_pkg.sv */
// ----------------------------------------------------------------------------
// idec_pkg
// shared types and constants for the signed integer to decimal text block
// ----------------------------------------------------------------------------
package idec_pkg;

  localparam int VALUE_W      = 32;
  localparam int CHAR_W       = 8;
  localparam int DIGIT_W      = 4;
  localparam int MAX_DIGITS   = 10;
  localparam int DIG_IDX_W    = $clog2(MAX_DIGITS);
  localparam int QUEUE_DEPTH  = 2;

  // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for every 32-bit n
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;
  localparam logic [7:0]         RADIX       = 8'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef struct packed {
    logic               negative;
    logic [VALUE_W-1:0] mag;
  } idec_item_t;

endpackage

/* design/idec_front.sv */
// ----------------------------------------------------------------------------
// idec_front
// input side: takes one value a beat while the queue is not full, splits it into sign and magnitude
// ----------------------------------------------------------------------------
module idec_front (
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [idec_pkg::VALUE_W-1:0]   in_value,
  output logic                                  push,
  output idec_pkg::idec_item_t                  push_item,
  input  logic                                  queue_full
);
  import idec_pkg::*;

  logic [VALUE_W-1:0] raw;

  assign raw      = VALUE_W'(in_value);
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // two's complement negation also covers the most negative value
  assign push_item.negative = raw[VALUE_W-1];
  assign push_item.mag      = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

endmodule

/* design/idec_queue.sv */
// ----------------------------------------------------------------------------
// idec_queue
// short fifo between the classifying front and the converting back
// ----------------------------------------------------------------------------
module idec_queue #(
  parameter int DEPTH = idec_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  idec_pkg::idec_item_t push_item,
  output logic                 full,
  output logic                 pop_valid,
  output idec_pkg::idec_item_t pop_item,
  input  logic                 pop
);
  import idec_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  idec_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* design/idec_back.sv */
// ----------------------------------------------------------------------------
// idec_back
// converter: one divide by ten a cycle into a digit buffer, then emits any
// minus sign and the digits most significant first through an output register
// ----------------------------------------------------------------------------
module idec_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  idec_pkg::idec_item_t               q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [idec_pkg::CHAR_W-1:0]        out_char_code,
  output logic                               out_is_last
);
  import idec_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [DIG_IDX_W-1:0] LAST_IDX = DIG_IDX_W'(MAX_DIGITS - 1);

  logic [1:0]           state_r, state_nxt;
  logic [VALUE_W-1:0]   mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIG_IDX_W-1:0] ptr_r, ptr_nxt;
  logic [DIGIT_W-1:0]   digs_r [MAX_DIGITS];
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [7:0]           quot_x10;
  logic [DIGIT_W-1:0]   digit;
  logic                 dig_we;
  logic                 out_free;

  // reciprocal multiply for the quotient; the remainder only needs four bits
  assign prod     = {{VALUE_W{1'b0}}, mag_r} * {{VALUE_W{1'b0}}, RECIP_TEN};
  assign quot     = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
  assign quot_x10 = {4'b0, quot[3:0]} * RADIX;
  assign digit    = mag_r[DIGIT_W-1:0] - quot_x10[DIGIT_W-1:0];

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    dig_we        = 1'b0;
    q_pop         = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          mag_nxt   = q_item.mag;
          neg_nxt   = q_item.negative;
          ptr_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        dig_we  = 1'b1;
        mag_nxt = quot;
        // ptr stays on the most significant digit once the quotient runs out
        if (quot == '0 || ptr_r == LAST_IDX) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + CHAR_W'(digs_r[ptr_r]);
          out_last_nxt  = (ptr_r == '0);
          if (ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt = ptr_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    ptr_r      <= ptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (dig_we) begin
      digs_r[ptr_r] <= digit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_is_last   = out_last_r;

`ifndef SYNTHESIS
  a_sign_only_negative: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIGN) |-> neg_r
  ) else $error("sign state entered for a non-negative value");

  a_digit_in_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (digit <= DIGIT_W'(9))
  ) else $error("remainder of divide by ten out of range");

  a_tenth_digit_small: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && ptr_r == LAST_IDX) |-> (mag_r < VALUE_W'(10))
  ) else $error("magnitude has more than ten digits");
`endif

endmodule

/* design/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed 32-bit integer to decimal ascii text, one character per beat
// ----------------------------------------------------------------------------
// usage: an input beat (in_valid high, in_stall low) carries one signed value.
// the result channel then gives its text one character a beat: a minus sign
// for negative values, then the digits most significant first with no
// leading zeros; out_is_last marks the final character. zero gives "0".
// a front stage splits sign and magnitude into a short queue, so new values
// are taken while the back stage is still converting or emitting.
// the back stage takes one item at a time from the queue, produces one
// digit per cycle with a reciprocal divide by ten, then emits one character
// per cycle while the receiver does not stall, a minus sign first for
// negative values; it pops the next item only after the last character
// of the current one, so sustained rate is set by this back stage.
// reset (rst_n low, synchronous) empties the queue and the output register.
// when the receiver stalls, the held character stays on the output, the back
// stage waits, and once the queue fills in_stall is raised.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = idec_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [idec_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [idec_pkg::CHAR_W-1:0]         out_char_code,
  output logic                                out_is_last
);
  import idec_pkg::*;

  logic       push;
  idec_item_t push_item;
  logic       queue_full;
  logic       q_valid;
  idec_item_t q_item;
  logic       q_pop;

  idec_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  idec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .pop       (q_pop)
  );

  idec_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

endmodule
